/* sv/lru_set_assoc_cache_core_defines.svh */
// assertion macros used by the checker file
`ifndef LRU_SET_ASSOC_CACHE_CORE_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define LSAC_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("lsac check failed");

// condition implies consequence from the next cycle on
`define LSAC_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> conseq) \
    else $error("lsac check failed");

`endif

/* sv/lsac_pkg.sv */
package lsac_pkg;

  // set count and tag store width are fixed by the port widths
  localparam int SETS        = 256;
  localparam int SET_BITS    = 8;
  localparam int WAYS        = 4;
  localparam int TAG_BITS    = 20;
  localparam int IN_TAG_BITS = 20;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [1:0] {
    OUT_MISS_LOAD  = 2'd0,
    OUT_MISS_STORE = 2'd1,
    OUT_HIT_LOAD   = 2'd2,
    OUT_HIT_STORE  = 2'd3
  } outcome_t;

endpackage

/* sv/lru_set_assoc_cache_core.sv */
// channel   | handshake          | fields
// ----------+--------------------+---------------------------------------------------
// access in | start & !busy      | set_index[7:0], tag[19:0], cmd
// result    | done (one cycle)   | outcome[1:0], evicted_valid, evicted_tag[19:0],
//           |                    | evicted_dirty
//
// one access per cycle while busy is low; results pass stage 1, then the output registers
// the pace is set by the set row memory: read at acceptance, written back in the cycle after
// a back-to-back access to the same set takes the row from a bypass register
// reset (synchronous, rst) holds busy high and marks every set row as reset state;
// no clearing pass is needed, a per-set valid bit stands in for it
// the result is not held: done and the result fields last exactly one cycle
module lru_set_assoc_cache_core #(
  parameter int WAYS = lsac_pkg::WAYS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lsac_pkg::SET_BITS-1:0]      set_index,
  input  logic [lsac_pkg::IN_TAG_BITS-1:0]   tag,
  input  logic                               cmd,
  output logic                               done,
  output logic [1:0]                         outcome,
  output logic                               evicted_valid,
  output logic [lsac_pkg::IN_TAG_BITS-1:0]   evicted_tag,
  output logic                               evicted_dirty
);

  localparam int TB       = lsac_pkg::TAG_BITS;
  localparam int AGE_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  // way layout inside a row: {age, tag, dirty, valid}
  localparam int WAY_W    = 2 + TB + AGE_BITS;
  localparam int ROW_W    = WAYS * WAY_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WAYS - 1);

  // accept whenever out of reset
  logic acc;
  assign busy = rst;
  assign acc  = start & ~busy;

  // stage 1 registers: the access whose row is being read
  logic                         s1_v;
  logic [lsac_pkg::SET_BITS-1:0] s1_set;
  logic [TB-1:0]                s1_tag;
  logic                         s1_cmd;
  logic                         s1_row_ok;

  // per-set row valid: a row never written reads as the reset state
  logic [lsac_pkg::SETS-1:0]    set_valid;

  // bypass of the row written in the previous cycle
  logic                         byp_v;
  logic [lsac_pkg::SET_BITS-1:0] byp_set;
  logic [ROW_W-1:0]             byp_row;

  logic [ROW_W-1:0] ram_q;
  logic [ROW_W-1:0] new_row;

  logic [1:0]                   outcome_next;
  logic                         evicted_valid_next;
  logic [lsac_pkg::IN_TAG_BITS-1:0] evicted_tag_next;
  logic                         evicted_dirty_next;

  lsac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (lsac_pkg::SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_set),
    .wdata (new_row),
    .re    (acc),
    .raddr (set_index),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      byp_v     <= 1'b0;
      done      <= 1'b0;
      set_valid <= '0;
    end else begin
      s1_v  <= acc;
      byp_v <= s1_v;
      done  <= s1_v;
      if (s1_v) begin
        set_valid[s1_set] <= 1'b1;
      end
    end
    // payload, no reset needed
    s1_set         <= set_index;
    s1_tag         <= TB'(tag);
    s1_cmd         <= cmd;
    s1_row_ok      <= set_valid[set_index];
    byp_set        <= s1_set;
    byp_row        <= new_row;
    outcome        <= outcome_next;
    evicted_valid  <= evicted_valid_next;
    evicted_tag    <= evicted_tag_next;
    evicted_dirty  <= evicted_dirty_next;
  end

  // lookup, victim choice and age update for the row in stage 1
  always_comb begin
    logic                byp_hit;
    logic                use_reset;
    logic [ROW_W-1:0]    src_row;
    logic [WAYS-1:0]     w_valid;
    logic [WAYS-1:0]     w_dirty;
    logic [TB-1:0]       w_tag [WAYS];
    logic [AGE_BITS-1:0] w_age [WAYS];
    logic [WAYS-1:0]     match;
    logic [WAYS-1:0]     hit_sel;
    logic [WAYS-1:0]     vic_sel;
    logic                hit;
    logic                is_store;
    logic [AGE_BITS-1:0] hage;
    logic                vic_valid;
    logic                vic_dirty;
    logic [TB-1:0]       vic_tag;
    logic [AGE_BITS-1:0] n_age;
    logic                n_valid;
    logic                n_dirty;
    logic [TB-1:0]       n_tag;

    byp_hit   = byp_v && (byp_set == s1_set);
    use_reset = !byp_hit && !s1_row_ok;
    src_row   = byp_hit ? byp_row : ram_q;
    is_store  = (s1_cmd == lsac_pkg::CMD_STORE);

    // unpack the row
    for (int w = 0; w < WAYS; w++) begin
      if (use_reset) begin
        w_valid[w] = 1'b0;
        w_dirty[w] = 1'b0;
        w_tag[w]   = '0;
        w_age[w]   = AGE_MAX;
      end else begin
        w_valid[w] = src_row[w*WAY_W];
        w_dirty[w] = src_row[w*WAY_W + 1];
        w_tag[w]   = src_row[w*WAY_W + 2 +: TB];
        w_age[w]   = src_row[w*WAY_W + 2 + TB +: AGE_BITS];
      end
      match[w] = w_valid[w] && (w_tag[w] == s1_tag);
    end

    // lowest matching way wins; victim is the lowest way with the largest age
    for (int w = 0; w < WAYS; w++) begin
      hit_sel[w] = match[w];
      vic_sel[w] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < w) begin
          if (match[j]) hit_sel[w] = 1'b0;
          if (!(w_age[w] > w_age[j])) vic_sel[w] = 1'b0;
        end else if (j > w) begin
          if (w_age[w] < w_age[j]) vic_sel[w] = 1'b0;
        end
      end
    end
    hit = |match;

    hage      = '0;
    vic_valid = 1'b0;
    vic_dirty = 1'b0;
    vic_tag   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_sel[w]) hage = hage | w_age[w];
      if (vic_sel[w]) begin
        vic_valid = vic_valid | w_valid[w];
        vic_dirty = vic_dirty | w_dirty[w];
        vic_tag   = vic_tag | w_tag[w];
      end
    end

    // new row
    new_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      n_valid = w_valid[w];
      n_dirty = w_dirty[w];
      n_tag   = w_tag[w];
      if (hit) begin
        // younger ways age by one, hit way becomes youngest
        n_age = (w_age[w] < hage) ? w_age[w] + AGE_BITS'(1) : w_age[w];
        if (hit_sel[w]) begin
          n_age = '0;
          if (is_store) n_dirty = 1'b1;
        end
      end else begin
        // saturating age-up, victim refilled as youngest
        n_age = (w_age[w] < AGE_MAX) ? w_age[w] + AGE_BITS'(1) : w_age[w];
        if (vic_sel[w]) begin
          n_age   = '0;
          n_valid = 1'b1;
          n_dirty = is_store;
          n_tag   = s1_tag;
        end
      end
      new_row[w*WAY_W]                     = n_valid;
      new_row[w*WAY_W + 1]                 = n_dirty;
      new_row[w*WAY_W + 2 +: TB]           = n_tag;
      new_row[w*WAY_W + 2 + TB +: AGE_BITS] = n_age;
    end

    // result fields
    if (hit) begin
      outcome_next        = is_store ? lsac_pkg::OUT_HIT_STORE : lsac_pkg::OUT_HIT_LOAD;
      evicted_valid_next  = 1'b0;
      evicted_tag_next    = '0;
      evicted_dirty_next  = 1'b0;
    end else begin
      outcome_next        = is_store ? lsac_pkg::OUT_MISS_STORE : lsac_pkg::OUT_MISS_LOAD;
      evicted_valid_next  = vic_valid;
      evicted_tag_next    = vic_valid ? lsac_pkg::IN_TAG_BITS'(vic_tag) : '0;
      evicted_dirty_next  = vic_dirty;
    end
  end

endmodule

/* sv/lsac_ram.sv */
module lsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* sv/lsac_checker.sv */
`include "lru_set_assoc_cache_core_defines.svh"

module lsac_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [lsac_pkg::SET_BITS-1:0]    set_index,
  input logic [lsac_pkg::IN_TAG_BITS-1:0] tag,
  input logic                             cmd,
  input logic                             done,
  input logic [1:0]                       outcome,
  input logic                             evicted_valid,
  input logic [lsac_pkg::IN_TAG_BITS-1:0] evicted_tag,
  input logic                             evicted_dirty
);

  logic acc;
  logic is_hit;
  assign acc    = start && !busy;
  assign is_hit = (outcome == lsac_pkg::OUT_HIT_LOAD) ||
                  (outcome == lsac_pkg::OUT_HIT_STORE);

  // every accepted transaction yields a result once it has passed stage 1
  `LSAC_ASSERT_NEXT(a_latency, acc, ##1 done)

  // no result without a transaction, and the access kind is carried through
  `LSAC_ASSERT_NOW(a_origin, done, $past(acc, 2) && (outcome[0] == $past(cmd, 2)))

  // hits report no eviction
  `LSAC_ASSERT_NOW(a_hit_clean, done && is_hit,
                   !evicted_valid && (evicted_tag == '0) && !evicted_dirty)

  // only a valid line can be evicted dirty
  `LSAC_ASSERT_NOW(a_dirty_valid, done && evicted_dirty, evicted_valid)

  // a repeat of the previous address right behind it must hit
  `LSAC_ASSERT_NOW(a_repeat_hit,
                   acc && $past(acc) && (set_index == $past(set_index)) && (tag == $past(tag)),
                   ##2 (done && is_hit))

endmodule

bind lru_set_assoc_cache_core lsac_checker u_lsac_checker (.*);
